### rtl/core/dcs_pkg.sv
// Shared types, constants and helpers for the difference-constraint engine.
// No dependencies.
`timescale 1ns / 1ps
package dcs_pkg;
  localparam int unsigned NodesDefault = 32;
  localparam int unsigned EdgesDefault = 1024;
  localparam int unsigned QueueDepthDefault = 64;
  localparam logic [5:0] NodeCountReset = 6'd25;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_ADD    = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_RUN    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_CYCLE    = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [4:0]  from_node;
    logic [4:0]  to_node;
    logic [15:0] weight;
    logic [4:0]  source_node;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  node;
    logic [31:0] distance;
    logic        reached;
    logic        last;
  } rsp_t;

  // Signed 32-bit add of a 16-bit weight, saturating.
  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] w);
    logic [32:0] s;
    begin
      s = {a[31], a} + {{17{w[15]}}, w};
      if (s[32] != s[31]) sat_add = s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
      else sat_add = s[31:0];
    end
  endfunction
endpackage

### rtl/core/dcs_stream_if.sv
// Valid/ready channel carrying one payload beat.
// Depends on nothing but its type parameter.
`timescale 1ns / 1ps
interface dcs_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/dcs_ctrl.sv
// Sequencer of the engine: edge table, lists, work queue and relaxation.
// Depends on dcs_pkg.
`timescale 1ns / 1ps
module dcs_ctrl #(
  parameter int unsigned Nodes = dcs_pkg::NodesDefault,
  parameter int unsigned Edges = dcs_pkg::EdgesDefault,
  parameter int unsigned QueueDepth = dcs_pkg::QueueDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [5:0]    node_count_i,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  dcs_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output dcs_pkg::rsp_t rsp_o
);
  import dcs_pkg::*;
  localparam int unsigned NW = (Nodes > 1) ? $clog2(Nodes) : 1;
  localparam int unsigned EW = $clog2(Edges);
  localparam int unsigned QW = $clog2(QueueDepth);
  localparam int unsigned CW = $clog2(Nodes + 1);

  typedef enum logic [13:0] {
    S_IDLE   = 14'h0001,
    S_RMRD   = 14'h0002,
    S_RMCHK  = 14'h0004,
    S_INIT   = 14'h0008,
    S_POP    = 14'h0010,
    S_POPW   = 14'h0020,
    S_EDGE   = 14'h0040,
    S_EDGEW  = 14'h0080,
    S_RELAX  = 14'h0100,
    S_DUMP   = 14'h0200,
    S_DUMPW  = 14'h0400,
    S_RESP   = 14'h0800,
    S_CLR    = 14'h1000,
    S_LOADU  = 14'h2000
  } state_e;

  state_e state_q;

  logic [4:0]  tgt_mem [Edges];
  logic [EW-1:0] lnk_mem [Edges];
  logic [15:0] cost_mem [Edges];
  logic [31:0] dist_mem [Nodes];
  logic [NW-1:0] queue_mem [QueueDepth];

  logic [EW-1:0] head_q [Nodes];
  logic [Nodes-1:0] queued_q, reach_q;
  logic [CW-1:0] cnt_q [Nodes];
  logic [EW:0] ecount_q;
  logic [QW-1:0] rd_q, wr_q;

  req_t req_q;
  logic [CW-1:0] n_q;
  logic [NW-1:0] u_q, node_q;
  logic [EW-1:0] cur_q, prev_q;
  logic [4:0]  tgt_rd;
  logic [EW-1:0] lnk_rd;
  logic [15:0] cost_rd;
  logic [31:0] du_q, dv_rd;
  logic [NW-1:0] qrd;
  rsp_t rsp_q;
  logic rsp_v_q;

  logic [CW-1:0] n_eff;
  logic [NW-1:0] from_n, to_n, src_n, v_n;
  logic [31:0] cand;
  logic [EW-1:0] rd_addr, mem_wa;
  logic [NW-1:0] dist_ra;
  logic [QW-1:0] q_wa;
  logic src_ok;

  always_comb begin
    if (node_count_i == 6'd0) n_eff = CW'(1);
    else if ({26'd0, node_count_i} > 32'(Nodes)) n_eff = CW'(Nodes);
    else n_eff = CW'(node_count_i);
  end
  assign from_n = NW'(req_q.from_node);
  assign to_n = NW'(req_q.to_node);
  assign src_n = NW'(req_q.source_node);
  assign v_n = NW'(tgt_rd);
  assign cand = sat_add(du_q, cost_rd);
  assign mem_wa = EW'(ecount_q + 1'b1);
  assign src_ok = ({1'b0, src_n} < (NW+1)'(n_q));
  // The start of a run places its node in the first queue slot when the source node is in range.
  assign q_wa = (state_q == S_INIT) ? '0 : wr_q;

  assign req_ready_o = (state_q == S_IDLE) && !rsp_v_q;
  assign rsp_valid_o = rsp_v_q;
  assign rsp_o = rsp_q;

  // Edge memories: one read port each, registered.
  always_ff @(posedge clk_i) begin
    tgt_rd <= tgt_mem[rd_addr];
    lnk_rd <= lnk_mem[rd_addr];
    cost_rd <= cost_mem[rd_addr];
    dv_rd <= dist_mem[dist_ra];
    qrd <= queue_mem[rd_q];
  end

  assign rd_addr = cur_q;
  always_comb begin
    dist_ra = u_q;
    if (state_q == S_POPW) dist_ra = qrd;
    if (state_q == S_EDGE || state_q == S_EDGEW) dist_ra = v_n;
    if (state_q == S_DUMP || state_q == S_DUMPW) dist_ra = node_q;
  end

  logic add_we, dist_we, q_we, lnk_we;
  logic [NW-1:0] dist_wa, q_wd;
  logic [31:0] dist_wd;
  logic [EW-1:0] lnk_wa, lnk_wd;

  always_ff @(posedge clk_i) begin
    if (add_we) begin
      tgt_mem[mem_wa] <= req_q.to_node;
      cost_mem[mem_wa] <= req_q.weight;
    end
    if (add_we) lnk_mem[mem_wa] <= head_q[from_n];
    else if (lnk_we) lnk_mem[lnk_wa] <= lnk_wd;
    if (dist_we) dist_mem[dist_wa] <= dist_wd;
    if (q_we) queue_mem[q_wa] <= q_wd;
  end

  logic do_add, accept, better, admit, closes_cycle;
  assign accept = req_valid_i && req_ready_o;
  assign better = !reach_q[v_n] || ($signed(dv_rd) < $signed(cand));
  assign admit = ({1'b0, v_n} < (NW+1)'(n_q));
  assign closes_cycle = admit && better && !queued_q[v_n] && (cnt_q[v_n] >= n_q);

  always_comb begin
    add_we = 1'b0; dist_we = 1'b0; q_we = 1'b0; lnk_we = 1'b0;
    dist_wa = u_q; dist_wd = '0; q_wd = src_n;
    lnk_wa = prev_q; lnk_wd = lnk_rd;
    do_add = (state_q == S_RESP) && req_q.func == FUNC_ADD &&
             ecount_q < (EW+1)'(Edges - 1) && !rsp_v_q;
    add_we = do_add;
    unique case (state_q)
      S_INIT: begin
        dist_we = src_ok;
        dist_wa = src_n; dist_wd = '0;
        q_we = dist_we; q_wd = src_n;
      end
      S_RELAX: begin
        dist_we = admit && better && !closes_cycle;
        dist_wa = v_n; dist_wd = cand;
        q_we = dist_we && !queued_q[v_n]; q_wd = v_n;
      end
      S_RMCHK: lnk_we = (tgt_rd == req_q.to_node) && prev_q != '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rsp_v_q <= 1'b0;
      ecount_q <= '0;
      queued_q <= '0;
      reach_q <= '0;
      rd_q <= '0;
      wr_q <= '0;
      for (int i = 0; i < Nodes; i++) begin
        head_q[i] <= '0;
        cnt_q[i] <= '0;
      end
    end else begin
      if (rsp_v_q && rsp_ready_i) rsp_v_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (accept) begin
          req_q <= req_i;
          n_q <= n_eff;
          unique case (func_e'(req_i.func))
            FUNC_CLEAR: state_q <= S_CLR;
            FUNC_ADD: state_q <= S_RESP;
            FUNC_REMOVE: begin
              cur_q <= head_q[NW'(req_i.from_node)];
              prev_q <= '0;
              state_q <= S_RMRD;
            end
            FUNC_RUN: state_q <= S_INIT;
            default: ;
          endcase
        end
        S_CLR: begin
          for (int i = 0; i < Nodes; i++) head_q[i] <= '0;
          ecount_q <= '0;
          rsp_q <= '{ST_OK, 5'd0, 32'd0, 1'b0, 1'b1};
          rsp_v_q <= 1'b1;
          state_q <= S_IDLE;
        end
        S_RESP: if (!rsp_v_q) begin
          if (do_add) begin
            head_q[from_n] <= mem_wa;
            ecount_q <= ecount_q + 1'b1;
          end
          rsp_q <= '{do_add ? ST_OK : ST_FULL, 5'd0, 32'd0, 1'b0, 1'b1};
          rsp_v_q <= 1'b1;
          state_q <= S_IDLE;
        end
        S_RMRD: begin
          if (cur_q == '0) begin
            rsp_q <= '{ST_NOTFOUND, 5'd0, 32'd0, 1'b0, 1'b1};
            rsp_v_q <= 1'b1;
            state_q <= S_IDLE;
          end else state_q <= S_RMCHK;
        end
        S_RMCHK: begin
          if (tgt_rd == req_q.to_node) begin
            if (prev_q == '0) head_q[from_n] <= lnk_rd;
            rsp_q <= '{ST_OK, 5'd0, 32'd0, 1'b0, 1'b1};
            rsp_v_q <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            prev_q <= cur_q;
            cur_q <= lnk_rd;
            state_q <= S_RMRD;
          end
        end
        S_INIT: begin
          queued_q <= src_ok ? (Nodes'(1) << src_n) : '0;
          reach_q <= src_ok ? (Nodes'(1) << src_n) : '0;
          rd_q <= '0;
          wr_q <= src_ok ? QW'(1) : '0;
          for (int i = 0; i < Nodes; i++)
            cnt_q[i] <= (src_ok && NW'(i) == src_n) ? CW'(1) : '0;
          state_q <= S_POP;
        end
        S_POP: begin
          if (rd_q == wr_q) begin
            node_q <= '0;
            state_q <= S_DUMP;
          end else state_q <= S_POPW;
        end
        S_POPW: begin
          u_q <= qrd;
          cur_q <= head_q[qrd];
          queued_q[qrd] <= 1'b0;
          rd_q <= rd_q + 1'b1;
          state_q <= S_LOADU;
        end
        S_LOADU: begin
          du_q <= dv_rd;
          state_q <= S_EDGE;
        end
        S_EDGE: begin
          if (cur_q == '0) state_q <= S_POP;
          else state_q <= S_EDGEW;
        end
        S_EDGEW: state_q <= S_RELAX;
        S_RELAX: begin
          if (q_we) wr_q <= wr_q + 1'b1;
          // A self-loop updates the distance of the node being expanded.
          if (dist_we && v_n == u_q) du_q <= cand;
          if (closes_cycle) begin
            rsp_q <= '{ST_CYCLE, 5'd0, 32'd0, 1'b0, 1'b1};
            rsp_v_q <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            cur_q <= lnk_rd;
            state_q <= S_EDGE;
            if (admit && better) begin
              reach_q[v_n] <= 1'b1;
              if (!queued_q[v_n]) begin
                queued_q[v_n] <= 1'b1;
                cnt_q[v_n] <= cnt_q[v_n] + 1'b1;
              end
            end
          end
        end
        S_DUMP: if (!rsp_v_q) state_q <= S_DUMPW;
        S_DUMPW: begin
          rsp_q <= '{ST_OK, 5'(node_q), reach_q[node_q] ? dv_rd : 32'd0,
                     reach_q[node_q], (CW'(node_q) + 1'b1) == n_q};
          rsp_v_q <= 1'b1;
          node_q <= node_q + 1'b1;
          if ((CW'(node_q) + 1'b1) == n_q) state_q <= S_IDLE;
          else state_q <= S_DUMP;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

### rtl/core/difference_constraint_spfa.sv
// Top level of the difference-constraint engine: config register and channels.
// Depends on dcs_pkg, dcs_stream_if and dcs_ctrl.
`timescale 1ns / 1ps
// Each request beat is handled alone, and the request side stays not ready
// while an answer beat waits in the output register. Clear and add answer
// from the state entered on acceptance. Remove visits each list element in
// a read and a check state; a read state at the end of the list answers not
// found. A run starts in an init state, takes each queue pop through pop,
// pop-wait and load states, each edge through edge, edge-wait and relax
// states, and finds the queue empty in the pop state, then reports each
// node's distance while the receiver keeps up, all paced by the single read
// port of the edge memories under one sequencer. No clearing pass after reset.
module difference_constraint_spfa #(
  parameter int unsigned Nodes = dcs_pkg::NodesDefault,
  parameter int unsigned Edges = dcs_pkg::EdgesDefault,
  parameter int unsigned QueueDepth = dcs_pkg::QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_wdata_i,
  dcs_stream_if.sink   req,
  dcs_stream_if.source rsp
);
  import dcs_pkg::*;
  logic [5:0] node_count_q;

  // The node count is to be written only while the engine is idle; the block itself does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) node_count_q <= NodeCountReset;
    else if (cfg_we_i) node_count_q <= cfg_wdata_i;
  end

  dcs_ctrl #(.Nodes(Nodes), .Edges(Edges), .QueueDepth(QueueDepth)) u_ctrl (
    .clk_i, .rst_ni,
    .node_count_i(node_count_q),
    .req_valid_i(req.valid), .req_ready_o(req.ready), .req_i(req.data),
    .rsp_valid_o(rsp.valid), .rsp_ready_i(rsp.ready), .rsp_o(rsp.data)
  );
endmodule
